>>> design/fmss_pkg.sv
// Package for the Fibonacci multiplexed seven-segment driver.
// Holds the digit count, the field widths, the segment table and the BCD helpers.
// No dependencies; the driver module uses these items by scoped name.
package fmss_pkg;

  // Number of BCD digits that a term keeps (range 1 to 6).
  localparam int unsigned DIGITS   = 4;
  localparam int unsigned TermW    = 4 * DIGITS;
  localparam int unsigned PosW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Fixed field widths of the streams and the registers.
  localparam int unsigned FramesW  = 16;
  localparam int unsigned TermsW   = 5;
  localparam int unsigned SegW     = 8;
  localparam int unsigned EnW      = 4;
  localparam int unsigned ShownW   = 14;
  localparam int unsigned ScanW    = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [FramesW-1:0] FramesReset = FramesW'(250);
  localparam logic [TermsW-1:0]  TermsReset  = TermsW'(19);
  localparam logic [TermW-1:0]   BcdOne      = TermW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgFramesPerTerm     = 2'd0,
    CfgTermsBeforeRestart = 2'd1
  } cfg_index_e;

  // Active-low segment patterns for digits 0 to 9, bit 0 is segment a.
  localparam logic [SegW-1:0] DigitPattern [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  // Digit-wise BCD add; the carry out of the top digit is dropped.
  function automatic logic [TermW-1:0] bcd_add(input logic [TermW-1:0] a,
                                               input logic [TermW-1:0] b);
    logic [TermW-1:0] r;
    logic [4:0]       s;
    logic             carry;
    r     = '0;
    carry = 1'b0;
    for (int unsigned p = 0; p < DIGITS; p++) begin
      s = {1'b0, a[4*p +: 4]} + {1'b0, b[4*p +: 4]} + {4'd0, carry};
      if (s > 5'd9) begin
        s     = s - 5'd10;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      r[4*p +: 4] = s[3:0];
    end
    return r;
  endfunction

  // Binary value of a BCD term, kept modulo 2^ShownW.
  function automatic logic [ShownW-1:0] bcd_value(input logic [TermW-1:0] v);
    logic [ShownW-1:0] r;
    r = '0;
    for (int p = DIGITS - 1; p >= 0; p--) begin
      r = ShownW'(r * ShownW'(10)) + ShownW'(v[4*p +: 4]);
    end
    return r;
  endfunction

endpackage

>>> design/fibonacci_multiplexed_seven_segment.sv
// Fibonacci multiplexed seven-segment driver, top level.
// Depends on fmss_pkg for widths, the segment table and the BCD helpers.
//
// One input transaction per millisecond tick drives a multiplexed display of
// fmss_pkg::DIGITS digits showing the Fibonacci terms 1, 2, 3, 5, ... in BCD,
// ones digit first, leading zeros shown. Each accepted transaction yields one
// output transaction carrying the drive for the digit now scanned: segments
// (active high, bit 0 is segment a), one-hot digit enable (8 ones, 4 tens,
// 2 hundreds, 1 thousands), the binary value of the shown term and the scan
// position. With advance set the scan then steps on; after frames_per_term
// full frames the next term appears, and after terms_before_restart terms the
// sequence restarts at 1. Terms wider than the display lose their top digits.
// Throughput is one transaction per clock: the digit decode sits between the
// state registers and a single output register, and input ready stays high
// while that register is empty or being drained. Each result is valid in the
// cycle after acceptance. Write configuration only while no output is pending.
module fibonacci_multiplexed_seven_segment (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side: tdata[0] advance
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fmss_pkg::InDataW-1:0]        s_axis_tdata,
  // master side: tdata[7:0] segments, [11:8] digit_enable,
  // [25:12] shown_value, [27:26] scan_digit, [31:28] zero
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fmss_pkg::OutDataW-1:0]       m_axis_tdata,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fmss_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [fmss_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned TermW = fmss_pkg::TermW;
  localparam int unsigned PosW  = fmss_pkg::PosW;

  // Configuration registers
  logic [fmss_pkg::FramesW-1:0] frames_q;
  logic [fmss_pkg::TermsW-1:0]  terms_max_q;

  // Sequence state
  logic [TermW-1:0]             older_q, older_d;
  logic [TermW-1:0]             newer_q, newer_d;
  logic                         upd_older_q, upd_older_d;
  logic [TermW-1:0]             disp_q, disp_d;
  logic [fmss_pkg::TermsW-1:0]  shown_q, shown_d;
  logic [fmss_pkg::FramesW-1:0] frame_q, frame_d;
  logic [PosW-1:0]              scan_q, scan_d;

  // Output register
  logic                          out_valid_q;
  logic [fmss_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic                          in_fire;
  logic                          advance;
  logic [3:0]                    digit;
  logic [fmss_pkg::SegW-1:0]     pattern;
  logic [PosW-1:0]               enable_pos;
  logic [fmss_pkg::EnW-1:0]      enable;
  logic [fmss_pkg::FramesW-1:0]  frame_inc;
  logic [TermW-1:0]              next_term;

  // Accept a new transaction whenever the output slot is free or draining.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign advance       = s_axis_tdata[0];
  assign cfg_ready_o   = 1'b1;

  // Decode the digit under the scan.
  always_comb begin
    digit      = disp_q[{scan_q, 2'b00} +: 4];
    pattern    = (digit < 4'd10) ? fmss_pkg::DigitPattern[digit] : 8'hFF;
    enable_pos = PosW'(fmss_pkg::DIGITS - 1) - scan_q;
    enable     = (enable_pos < 4) ? fmss_pkg::EnW'(4'b0001 << enable_pos) : '0;
    out_data_d = {4'b0000, fmss_pkg::ScanW'(scan_q), fmss_pkg::bcd_value(disp_q),
                  enable, ~pattern};
  end

  // Next-state logic for scan, frame count and term sequence.
  always_comb begin
    older_d     = older_q;
    newer_d     = newer_q;
    upd_older_d = upd_older_q;
    disp_d      = disp_q;
    shown_d     = shown_q;
    frame_d     = frame_q;
    scan_d      = scan_q;
    frame_inc   = frame_q + 1'b1;
    next_term   = fmss_pkg::bcd_add(older_q, newer_q);
    if (in_fire && advance) begin
      if (scan_q != PosW'(fmss_pkg::DIGITS - 1)) begin
        scan_d = scan_q + 1'b1;
      end else begin
        scan_d  = '0;
        frame_d = frame_inc;
        // A count at or above the register ends the term (zero acts as one).
        if (frame_inc >= frames_q) begin
          frame_d = '0;
          if (shown_q >= terms_max_q) begin
            older_d     = fmss_pkg::BcdOne;
            newer_d     = fmss_pkg::BcdOne;
            upd_older_d = 1'b0;
            disp_d      = fmss_pkg::BcdOne;
            shown_d     = fmss_pkg::TermsW'(1);
          end else begin
            if (upd_older_q) begin
              older_d = next_term;
            end else begin
              newer_d = next_term;
            end
            upd_older_d = !upd_older_q;
            disp_d      = next_term;
            shown_d     = shown_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= fmss_pkg::FramesReset;
      terms_max_q <= fmss_pkg::TermsReset;
      older_q     <= fmss_pkg::BcdOne;
      newer_q     <= fmss_pkg::BcdOne;
      upd_older_q <= 1'b0;
      disp_q      <= fmss_pkg::BcdOne;
      shown_q     <= fmss_pkg::TermsW'(1);
      frame_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          fmss_pkg::CfgFramesPerTerm:      frames_q    <= cfg_data_i;
          fmss_pkg::CfgTermsBeforeRestart: terms_max_q <= cfg_data_i[fmss_pkg::TermsW-1:0];
          default: ;
        endcase
      end
      older_q     <= older_d;
      newer_q     <= newer_d;
      upd_older_q <= upd_older_d;
      disp_q      <= disp_d;
      shown_q     <= shown_d;
      frame_q     <= frame_d;
      scan_q      <= scan_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload register: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  // The shown term is always one of the two running terms.
  a_disp_is_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (disp_q == older_q) || (disp_q == newer_q))
    else $error("displayed term differs from both running terms");

  // The term counter never wraps to zero.
  a_shown_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_q != '0)
    else $error("terms shown counter reached zero");

  // A transaction without advance leaves scan and term untouched.
  a_hold_no_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !advance) |=> ($stable(scan_q) && $stable(disp_q) && $stable(frame_q)))
    else $error("state moved on a report-only transaction");

  // An accepted transaction always leaves a result pending.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction produced no result");
`endif

endmodule
